/* rtl/core/fspr_pkg.sv */
// Package for the framed status packet receiver.
// Holds the per-channel context type, result codes and byte constants.
// No dependencies.
package fspr_pkg;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [1:0] KIND_ACCEPT  = 2'd0;
  localparam logic [1:0] KIND_REJECT  = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  localparam logic [1:0] SVC_MISSING = 2'd3;

  localparam logic [1:0] REG_START   = 2'd0;
  localparam logic [1:0] REG_END     = 2'd1;
  localparam logic [1:0] REG_FLOORS  = 2'd2;
  localparam logic [1:0] REG_TIMEOUT = 2'd3;

  typedef struct packed {
    logic        in_frame;
    logic [7:0]  byte_count;
    logic        nul_seen;
    logic [2:0]  comma_count;
    logic [7:0]  token_value;
    logic        tok_nonempty;
    logic        tok_neg;
    logic        tok_bad;
    logic        rec_bad;
    logic [16:0] pending;
    logic [16:0] last_rec;
    logic [15:0] elapsed;
    logic        timed_out;
    logic [15:0] reject_count;
  } ctx_t;

  typedef struct packed {
    logic        ch;
    logic [1:0]  kind;
    logic [16:0] rec;
    logic [1:0]  svc;
    logic [15:0] errs;
  } result_t;

endpackage

/* rtl/core/framed_status_packet_receiver.sv */
// Top level of the framed status packet receiver.
// Holds the context memory, input/output stages and config registers;
// uses fspr_pkg and fspr_step.
//
//  channel   | dir | beat contents
//  ----------+-----+---------------------------------------------------
//  s_axis    | in  | tdata: channel[0] data_byte[8:1]; tuser: op
//  m_axis    | out | tdata: out_channel..error_count; tuser: result_kind
//  cfg       | in  | cfg_index (register), cfg_data (value)
//
// Each beat is read, then updated: the accepting edge reads the channel
// context from the memory; the update writes the new context back and loads
// any result into the output register. A new beat is taken every cycle
// while tready is high; a beat to the channel in update takes the freshly written
// context by forwarding. The output and skid registers hold results while
// m_axis stalls; hold off s_axis while the skid register is full, or while
// a result is about to land on a full output register that is not draining.
// Reset clears all contexts by valid bits (one per channel), so no clearing
// pass is needed.
module framed_status_packet_receiver #(
  parameter int CHANNELS    = 2,
  parameter int FRAME_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // channel[0], data_byte[8:1], zero pad
  input  logic        s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_channel[0], floor_pos[6:1], target_floor[12:7], occupied[13],
  // direction[15:14], service[17:16], error_count[33:18], zero pad
  output logic [39:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,  // result_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers
  logic [7:0]  open_byte;
  logic [7:0]  close_byte;
  logic [6:0]  floor_count;
  logic [15:0] timeout_ticks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_byte <= 8'd60;
      close_byte <= 8'd62;
      floor_count <= 7'd8;
      timeout_ticks <= 16'd1000;
    end else if (cfg_valid) begin
      case (cfg_index)
        fspr_pkg::REG_START:   open_byte <= cfg_data[7:0];
        fspr_pkg::REG_END:     close_byte <= cfg_data[7:0];
        fspr_pkg::REG_FLOORS:  floor_count <= cfg_data[6:0];
        fspr_pkg::REG_TIMEOUT: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Context memory with one valid bit per channel
  fspr_pkg::ctx_t ctx_mem [CHANNELS];
  logic [CHANNELS-1:0] ctx_ok;

  // Stage 1: memory read in flight
  logic        s1_valid;
  logic        s1_op;
  logic        s1_ch;
  logic [7:0]  s1_byte;
  logic        s1_in_range;
  fspr_pkg::ctx_t rd_data;
  logic        rd_ok;

  // Stage 2 write-back (same cycle as update)
  logic        wr_en;
  logic [CW-1:0] wr_addr;
  fspr_pkg::ctx_t wr_data;

  // Output register plus skid
  logic              out_full;
  fspr_pkg::result_t out_res;
  logic              skid_full;
  fspr_pkg::result_t skid_res;
  logic              new_res;

  logic in_ch;
  logic [CW-1:0] in_addr;
  logic accept;
  assign in_ch = s_axis_tdata[0];
  assign in_addr = CW'(in_ch);
  // Take a beat only if its result is sure to find room next cycle
  assign s_axis_tready = !skid_full && !(out_full && new_res && !m_axis_tready);
  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= ctx_mem[in_addr];
      rd_ok <= ctx_ok[in_addr];
    end
    if (wr_en) ctx_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx_ok <= '0;
    end else if (wr_en) begin
      ctx_ok[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_op <= s_axis_tuser;
    s1_ch <= in_ch;
    s1_byte <= s_axis_tdata[8:1];
    s1_in_range <= 32'(in_ch) < CHANNELS;
  end

  // Forward the context written last cycle when the read hit the same entry
  logic        fwd_hit;
  logic [CW-1:0] s1_addr;
  logic        wr_en_d;
  logic [CW-1:0] wr_addr_d;
  fspr_pkg::ctx_t wr_data_d;
  fspr_pkg::ctx_t cur_ctx;

  assign s1_addr = CW'(s1_ch);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_en_d <= 1'b0;
    end else begin
      wr_en_d <= wr_en && accept && (wr_addr == in_addr);
    end
    wr_data_d <= wr_data;
    wr_addr_d <= wr_addr;
  end

  assign fwd_hit = wr_en_d && (wr_addr_d == s1_addr);

  always_comb begin
    if (fwd_hit) cur_ctx = wr_data_d;
    else if (rd_ok) cur_ctx = rd_data;
    else cur_ctx = '0;
  end

  fspr_pkg::ctx_t    step_next;
  logic              step_rv;
  fspr_pkg::result_t step_res;

  fspr_step #(.FRAME_BYTES(FRAME_BYTES)) u_step (
    .ctx           (cur_ctx),
    .op            (s1_op),
    .channel       (s1_ch),
    .data_byte     (s1_byte),
    .open_byte     (open_byte),
    .close_byte    (close_byte),
    .floor_count   (floor_count),
    .timeout_ticks (timeout_ticks),
    .ctx_next      (step_next),
    .res_valid     (step_rv),
    .res           (step_res)
  );

  assign wr_en = s1_valid && s1_in_range;
  assign wr_addr = s1_addr;
  assign wr_data = step_next;

  assign new_res = wr_en && step_rv;

  // Output register fills first; skid catches a result while the register waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
      skid_full <= 1'b0;
    end else begin
      if (!out_full || m_axis_tready) begin
        if (skid_full) begin
          out_full <= 1'b1;
          out_res <= skid_res;
          skid_full <= new_res;
          skid_res <= step_res;
        end else begin
          out_full <= new_res;
          out_res <= step_res;
        end
      end else if (new_res) begin
        skid_full <= 1'b1;
        skid_res <= step_res;
      end
    end
  end

  assign m_axis_tvalid = out_full;
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {6'd0, out_res.errs, out_res.svc, out_res.rec[14:13],
                         out_res.rec[12], out_res.rec[11:6], out_res.rec[5:0],
                         out_res.ch};

endmodule

/* rtl/core/fspr_step.sv */
// Per-item context update for the framed status packet receiver.
// Pure combinational next-state and result logic; uses fspr_pkg.
module fspr_step #(
  parameter int FRAME_BYTES = 32
) (
  input  fspr_pkg::ctx_t    ctx,
  input  logic              op,
  input  logic              channel,
  input  logic [7:0]        data_byte,
  input  logic [7:0]        open_byte,
  input  logic [7:0]        close_byte,
  input  logic [6:0]        floor_count,
  input  logic [15:0]       timeout_ticks,
  output fspr_pkg::ctx_t    ctx_next,
  output logic              res_valid,
  output fspr_pkg::result_t res
);

  localparam logic [7:0] KEEP_MAX = 8'(FRAME_BYTES - 1);

  // Check the current token as field comma_count and merge it into pending
  function automatic logic [17:0] finish_tok(input fspr_pkg::ctx_t c, input logic [6:0] fc);
    logic [6:0]  fcl;
    logic        ok;
    logic [16:0] r;
    logic [7:0]  v;
    fcl = (fc > 7'd64) ? 7'd64 : fc;
    v = c.token_value;
    r = c.pending;
    ok = c.tok_nonempty && !c.tok_bad && !(c.tok_neg && v != 8'd0);
    if (ok) begin
      case (c.comma_count)
        3'd0: begin
          ok = v < {1'b0, fcl};
          if (ok) r[5:0] = r[5:0] | v[5:0];
        end
        3'd1: begin
          ok = v < {1'b0, fcl};
          if (ok) r[11:6] = r[11:6] | v[5:0];
        end
        3'd2: begin
          ok = v <= 8'd1;
          if (ok) r[12] = r[12] | v[0];
        end
        3'd3: begin
          ok = v <= 8'd2;
          if (ok) r[14:13] = r[14:13] | v[1:0];
        end
        3'd4: begin
          if (v == 8'd1 || v == 8'd2 || v == 8'd3) r[16:15] = r[16:15] | v[1:0];
          else if (v != 8'd5) ok = 1'b0;
        end
        default: ok = 1'b0;
      endcase
    end
    return {~ok | c.rec_bad, r};
  endfunction

  logic [17:0] fin;
  logic [15:0] el_inc;
  logic [8:0]  mul_sum;
  logic [11:0] dig_val;

  assign fin = finish_tok(ctx, floor_count);
  assign el_inc = (ctx.elapsed != 16'hFFFF) ? ctx.elapsed + 16'd1 : ctx.elapsed;
  assign dig_val = 12'(ctx.token_value) * 12'd10 + 12'(data_byte - fspr_pkg::CHAR_ZERO);
  assign mul_sum = (dig_val > 12'd255) ? 9'd255 : dig_val[8:0];

  always_comb begin
    ctx_next = ctx;
    res_valid = 1'b0;
    res = '0;
    res.ch = channel;
    res.errs = ctx.reject_count;
    if (op) begin
      ctx_next.elapsed = el_inc;
      if (el_inc > timeout_ticks && !ctx.timed_out) begin
        ctx_next.timed_out = 1'b1;
        res_valid = 1'b1;
        res.kind = fspr_pkg::KIND_TIMEOUT;
        res.rec = ctx.last_rec;
        res.svc = fspr_pkg::SVC_MISSING;
      end
    end else if (!ctx.in_frame) begin
      if (data_byte == open_byte) begin
        ctx_next.in_frame = 1'b1;
        ctx_next.byte_count = '0;
        ctx_next.nul_seen = 1'b0;
        ctx_next.comma_count = '0;
        ctx_next.token_value = '0;
        ctx_next.tok_nonempty = 1'b0;
        ctx_next.tok_neg = 1'b0;
        ctx_next.tok_bad = 1'b0;
        ctx_next.rec_bad = 1'b0;
        ctx_next.pending = '0;
      end
    end else if (data_byte != close_byte) begin
      if (!ctx.nul_seen && ctx.byte_count < KEEP_MAX) begin
        ctx_next.byte_count = ctx.byte_count + 8'd1;
        if (data_byte == 8'd0) begin
          ctx_next.nul_seen = 1'b1;
        end else if (!ctx.rec_bad) begin
          if (data_byte == fspr_pkg::CHAR_COMMA) begin
            ctx_next.rec_bad = fin[17] | (ctx.comma_count >= 3'd4);
            ctx_next.pending = fin[16:0];
            ctx_next.token_value = '0;
            ctx_next.tok_nonempty = 1'b0;
            ctx_next.tok_neg = 1'b0;
            ctx_next.tok_bad = 1'b0;
            if (ctx.comma_count < 3'd4) ctx_next.comma_count = ctx.comma_count + 3'd1;
          end else if (data_byte == fspr_pkg::CHAR_MINUS && !ctx.tok_nonempty) begin
            ctx_next.tok_nonempty = 1'b1;
            ctx_next.tok_neg = 1'b1;
          end else if (data_byte >= fspr_pkg::CHAR_ZERO && data_byte <= fspr_pkg::CHAR_NINE) begin
            ctx_next.token_value = mul_sum[7:0];
            ctx_next.tok_nonempty = 1'b1;
          end else begin
            ctx_next.tok_nonempty = 1'b1;
            ctx_next.tok_bad = 1'b1;
          end
        end
      end
    end else begin
      res_valid = 1'b1;
      ctx_next.in_frame = 1'b0;
      if (ctx.rec_bad || fin[17] || ctx.comma_count != 3'd4) begin
        ctx_next.reject_count = ctx.reject_count + 16'd1;
        res.kind = fspr_pkg::KIND_REJECT;
        res.errs = ctx.reject_count + 16'd1;
      end else begin
        ctx_next.last_rec = fin[16:0];
        ctx_next.elapsed = '0;
        ctx_next.timed_out = 1'b0;
        res.kind = fspr_pkg::KIND_ACCEPT;
        res.rec = fin[16:0];
        res.svc = fin[16:15];
      end
      ctx_next.byte_count = '0;
      ctx_next.nul_seen = 1'b0;
      ctx_next.comma_count = '0;
      ctx_next.token_value = '0;
      ctx_next.tok_nonempty = 1'b0;
      ctx_next.tok_neg = 1'b0;
      ctx_next.tok_bad = 1'b0;
      ctx_next.rec_bad = 1'b0;
      ctx_next.pending = '0;
    end
  end

endmodule

/* sim/tb_framed_status_packet_receiver.sv */
// Self-checking testbench for the framed status packet receiver.
// Drives byte and tick beats on s_axis, predicts each result in a local model
// of the two channel contexts, and checks m_axis; depends on fspr_pkg.
`timescale 1ns / 1ps

module tb_framed_status_packet_receiver;

  localparam int NCH = 2;
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic        ch;
    logic [1:0]  kind;
    logic [5:0]  pos;
    logic [5:0]  target;
    logic        occ;
    logic [1:0]  dir;
    logic [1:0]  svc;
    logic [15:0] errs;
  } status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  framed_status_packet_receiver i_dut (.*);

  // Predictor copy of registers and per-channel context.
  logic [7:0]  p_start, p_end;
  logic [6:0]  p_floors;
  logic [15:0] p_timeout;
  logic        c_in[NCH], c_nul[NCH], c_tne[NCH], c_tneg[NCH], c_tbad[NCH];
  logic        c_bad[NCH], c_tmo[NCH];
  int          c_cnt[NCH], c_commas[NCH], c_tval[NCH];
  logic [16:0] c_rec[NCH], c_last[NCH];
  logic [15:0] c_ticks[NCH], c_rejects[NCH];

  status_t expected_status[$];
  int      fail_cnt = 0;
  int      result_cnt = 0;
  int      beat_cnt = 0;
  bit      calm = 1'b0;      // no idling on either side
  bit      hold_off = 1'b0;  // receiver held off for pressure test

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

  task automatic model_reset();
    p_start = 8'd60; p_end = 8'd62; p_floors = 7'd8; p_timeout = 16'd1000;
    for (int c = 0; c < NCH; c++) begin
      c_in[c] = 1'b0; c_nul[c] = 1'b0; c_tne[c] = 1'b0; c_tneg[c] = 1'b0;
      c_tbad[c] = 1'b0; c_bad[c] = 1'b0; c_tmo[c] = 1'b0;
      c_cnt[c] = 0; c_commas[c] = 0; c_tval[c] = 0;
      c_rec[c] = '0; c_last[c] = '0; c_ticks[c] = '0; c_rejects[c] = '0;
    end
  endtask

  task automatic frame_open(int c);
    c_cnt[c] = 0; c_nul[c] = 1'b0; c_commas[c] = 0; c_tval[c] = 0;
    c_tne[c] = 1'b0; c_tneg[c] = 1'b0; c_tbad[c] = 1'b0; c_rec[c] = '0;
    c_bad[c] = 1'b0;
  endtask

  // Close the current token as field idx of the record.
  task automatic token_close(int c, int idx);
    int  fc;
    int  v;
    bit  ok;
    v = c_tval[c];
    fc = (p_floors > 7'd64) ? 64 : int'(p_floors);
    ok = c_tne[c] && !c_tbad[c] && !(c_tneg[c] && v != 0);
    if (ok) begin
      case (idx)
        0: begin ok = v < fc; if (ok) c_rec[c][5:0] = v[5:0]; end
        1: begin ok = v < fc; if (ok) c_rec[c][11:6] = v[5:0]; end
        2: begin ok = v <= 1; if (ok) c_rec[c][12] = v[0]; end
        3: begin ok = v <= 2; if (ok) c_rec[c][14:13] = v[1:0]; end
        4: begin
          if (v >= 1 && v <= 3) c_rec[c][16:15] = v[1:0];
          else if (v != 5) ok = 1'b0;
        end
        default: ok = 1'b0;
      endcase
    end
    if (!ok) c_bad[c] = 1'b1;
    c_tval[c] = 0; c_tne[c] = 1'b0; c_tneg[c] = 1'b0; c_tbad[c] = 1'b0;
  endtask

  function automatic status_t make_status(int c, logic [1:0] kind, logic [16:0] rec,
                                          logic [1:0] svc);
    status_t s;
    s.ch = c[0]; s.kind = kind; s.pos = rec[5:0]; s.target = rec[11:6];
    s.occ = rec[12]; s.dir = rec[14:13]; s.svc = svc; s.errs = c_rejects[c];
    return s;
  endfunction

  // Advance the predictor by one accepted beat.
  task automatic predict_status(logic op, int c, logic [7:0] b);
    if (op == OP_TICK) begin
      if (c_ticks[c] != 16'hFFFF) c_ticks[c]++;
      if (c_ticks[c] > p_timeout && !c_tmo[c]) begin
        c_tmo[c] = 1'b1;
        expected_status.push_back(make_status(c, fspr_pkg::KIND_TIMEOUT, c_last[c],
                                              fspr_pkg::SVC_MISSING));
      end
    end else if (!c_in[c]) begin
      if (b == p_start) begin c_in[c] = 1'b1; frame_open(c); end
    end else if (b != p_end) begin
      if (!c_nul[c] && c_cnt[c] < 31) begin
        c_cnt[c]++;
        if (b == 8'h00) c_nul[c] = 1'b1;
        else if (!c_bad[c]) begin
          if (b == fspr_pkg::CHAR_COMMA) begin
            token_close(c, c_commas[c]);
            if (c_commas[c] >= 4) c_bad[c] = 1'b1;
            else c_commas[c]++;
          end else if (b == fspr_pkg::CHAR_MINUS && !c_tne[c]) begin
            c_tne[c] = 1'b1; c_tneg[c] = 1'b1;
          end else if (b >= fspr_pkg::CHAR_ZERO && b <= fspr_pkg::CHAR_NINE) begin
            c_tval[c] = c_tval[c] * 10 + int'(b - fspr_pkg::CHAR_ZERO);
            if (c_tval[c] > 255) c_tval[c] = 255;
            c_tne[c] = 1'b1;
          end else begin
            c_tne[c] = 1'b1; c_tbad[c] = 1'b1;
          end
        end
      end
    end else begin
      c_in[c] = 1'b0;
      if (!c_bad[c]) begin
        token_close(c, c_commas[c]);
        if (c_commas[c] != 4) c_bad[c] = 1'b1;
      end
      if (c_bad[c]) begin
        c_rejects[c]++;
        expected_status.push_back(make_status(c, fspr_pkg::KIND_REJECT, '0, 2'd0));
      end else begin
        c_last[c] = c_rec[c];
        c_ticks[c] = '0;
        c_tmo[c] = 1'b0;
        expected_status.push_back(make_status(c, fspr_pkg::KIND_ACCEPT, c_rec[c],
                                              c_rec[c][16:15]));
      end
      frame_open(c);
    end
  endtask

  // Send one beat; idle at random first unless in a calm stretch.
  task automatic send_beat(logic op, int c, logic [7:0] b);
    while (!calm && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {7'd0, b, c[0]};
    do @(posedge clk); while (!s_axis_tready);
    predict_status(op, c, b);
    beat_cnt++;
  endtask

  task automatic send_text(int c, string s);
    foreach (s[i]) send_beat(OP_BYTE, c, s[i]);
  endtask

  task automatic send_frame(int c, string body);
    send_beat(OP_BYTE, c, p_start);
    send_text(c, body);
    send_beat(OP_BYTE, c, p_end);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_status.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (expected_status.size() != 0) begin
      $display("FAIL");
      $finish;
    end
    // Let any beat that makes no result leave the two-stage pipe.
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    s_axis_tvalid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      fspr_pkg::REG_START:   p_start = val[7:0];
      fspr_pkg::REG_END:     p_end = val[7:0];
      fspr_pkg::REG_FLOORS:  p_floors = val[6:0];
      fspr_pkg::REG_TIMEOUT: p_timeout = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver side: random stalls, unless held off or calm.
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= !hold_off && (calm || $urandom_range(99) >= 16);
  end

  // Check each result beat against the oldest prediction.
  always @(posedge clk) begin
    status_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[0], m_axis_tuser, m_axis_tdata[6:1], m_axis_tdata[12:7],
             m_axis_tdata[13], m_axis_tdata[15:14], m_axis_tdata[17:16],
             m_axis_tdata[33:18]};
      result_cnt++;
      if (expected_status.size() == 0) begin
        $error("unexpected result beat %h", got);
        fail_cnt++;
      end else begin
        want = expected_status.pop_front();
        if (got !== want) begin
          fail_cnt++;
          if (got.ch !== want.ch) $error("out_channel exp %0d got %0d", want.ch, got.ch);
          if (got.kind !== want.kind) $error("result_kind exp %0d got %0d", want.kind, got.kind);
          if (got.pos !== want.pos) $error("floor_pos exp %0d got %0d", want.pos, got.pos);
          if (got.target !== want.target)
            $error("target_floor exp %0d got %0d", want.target, got.target);
          if (got.occ !== want.occ) $error("occupied exp %0d got %0d", want.occ, got.occ);
          if (got.dir !== want.dir) $error("direction exp %0d got %0d", want.dir, got.dir);
          if (got.svc !== want.svc) $error("service exp %0d got %0d", want.svc, got.svc);
          if (got.errs !== want.errs)
            $error("error_count exp %0d got %0d", want.errs, got.errs);
        end
      end
    end
  end

  // Directed: extremes, signs, NUL, overlong, markers, commas, both channels.
  task automatic test_directed();
    send_frame(0, "0,7,1,2,5");
    send_frame(1, "-,-0,0,0,1");
    send_frame(0, "8,0,0,0,5");
    send_frame(0, "1,2,0,1,3,");
    send_frame(1, "-1,2,0,1,2");
    send_frame(0, "1,,0,1,2");
    send_frame(1, "3,4,1,1,4");
    send_frame(0, "2,3,1,2,2");
    send_beat(OP_BYTE, 0, 8'h00);
    // NUL inside a frame cuts the text short
    send_beat(OP_BYTE, 1, p_start);
    send_text(1, "1,2,0,0,5");
    send_beat(OP_BYTE, 1, 8'h00);
    send_text(1, "xx");
    send_beat(OP_BYTE, 1, p_end);
    send_frame(0, "1,2,0,0,5,000000000000000000000099");
    send_frame(1, "1<2,0,0,5");
    send_frame(0, "999,2,0,0,5");
    send_beat(OP_BYTE, 1, 8'hFF);
    send_beat(OP_BYTE, 1, p_end);
  endtask

  task automatic test_timeout();
    write_reg(fspr_pkg::REG_TIMEOUT, 16'd0);
    send_beat(OP_TICK, 0, 8'hA5);
    send_beat(OP_TICK, 0, 8'h5A);
    send_frame(0, "5,6,1,1,1");
    send_beat(OP_TICK, 0, 8'h00);
    drain();
    write_reg(fspr_pkg::REG_TIMEOUT, 16'd3);
    for (int i = 0; i < 5; i++) send_beat(OP_TICK, 1, 8'h00);
    drain();
  endtask

  task automatic test_registers();
    write_reg(fspr_pkg::REG_START, 16'h00FF);
    write_reg(fspr_pkg::REG_END, 16'h0000);
    write_reg(fspr_pkg::REG_FLOORS, 16'd127);
    send_frame(0, "63,63,1,2,5");
    send_frame(1, "64,0,0,0,5");
    drain();
    write_reg(fspr_pkg::REG_FLOORS, 16'd0);
    write_reg(fspr_pkg::REG_START, 16'h002C);
    write_reg(fspr_pkg::REG_END, 16'h00C3);
    send_frame(0, "0,0,0,0,5");
    drain();
    write_reg(fspr_pkg::REG_FLOORS, 16'd1);
    send_frame(1, "0,0,0,0,5");
    drain();
    write_reg(fspr_pkg::REG_START, 16'd60);
    write_reg(fspr_pkg::REG_END, 16'd62);
    write_reg(fspr_pkg::REG_FLOORS, 16'd64);
    write_reg(fspr_pkg::REG_TIMEOUT, 16'd20);
  endtask

  function automatic string random_token(int max);
    int k;
    k = $urandom_range(99);
    if (k < 70) return $sformatf("%0d", $urandom_range(max));
    if (k < 80) return (k & 1) ? "-" : "-0";
    if (k < 90) return $sformatf("%0d", $urandom_range(300));
    return "";
  endfunction

  // Mostly well-formed frames with random fields, plus noise and ticks.
  task automatic test_random();
    string body;
    int    c;
    int    k;
    int    sent;
    sent = 0;
    while (sent < 330) begin
      c = $urandom_range(1);
      k = $urandom_range(99);
      calm = (sent >= 100 && sent < 200);
      if (k < 70) begin
        body = $sformatf("%s,%s,%s,%s,%s", random_token(70), random_token(70),
                         random_token(1), random_token(2), random_token(5));
        if ($urandom_range(9) == 0) body = {body, ",", random_token(9)};
        if ($urandom_range(19) == 0) body = {body, "x"};
        send_frame(c, body);
        sent += body.len() + 2;
      end else if (k < 85) begin
        send_beat(OP_TICK, c, 8'($urandom_range(255)));
        sent++;
      end else begin
        send_beat(OP_BYTE, c, 8'($urandom_range(255)));
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  // Hold the receiver off while frames keep coming, so the input stalls.
  task automatic test_backpressure();
    int stall_cycles;
    hold_off = 1'b1;
    fork
      begin
        stall_cycles = 0;
        while (stall_cycles < 300) begin
          @(posedge clk);
          stall_cycles++;
        end
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_frame(i % 2, "1,2,1,1,5");
    join
  endtask

  initial begin
    model_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain();
    test_timeout();
    test_registers();
    test_backpressure();
    drain();
    test_random();
    drain();
    repeat (20) @(posedge clk);
    $display("Ran %0d input beats, %0d results checked: frames, ticks, registers, stalls.",
             beat_cnt, result_cnt);
    if (fail_cnt == 0 && expected_status.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* framed_status_packet_receiver.f */
rtl/core/fspr_pkg.sv
rtl/core/fspr_step.sv
rtl/core/framed_status_packet_receiver.sv
sim/tb_framed_status_packet_receiver.sv
